### rtl/vn3d_pkg.sv
// Shared types and fixed field widths for the 3D lattice value noise block.
// No dependencies; imported by value_noise_3d_lattice_top.
package vn3d_pkg;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_LOAD  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        SEL_VALUE  = 2'd0,
        SEL_PERM_X = 2'd1,
        SEL_PERM_Y = 2'd2,
        SEL_PERM_Z = 2'd3
    } sel_t;

    localparam int unsigned AXES          = 3;
    localparam int unsigned CORNERS       = 8;
    localparam int unsigned COORD_W       = 32;
    localparam int unsigned ENTRY_INDEX_W = 8;
    localparam int unsigned ENTRY_VALUE_W = 16;
    localparam int unsigned NOISE_W       = 16;

    // Axis order x, y, z
    localparam sel_t PERM_SEL [AXES] = '{SEL_PERM_X, SEL_PERM_Y, SEL_PERM_Z};

    // Input item payload, first member in the highest bits
    typedef struct packed {
        logic [COORD_W-1:0]       coord_z;
        logic [COORD_W-1:0]       coord_y;
        logic [COORD_W-1:0]       coord_x;
        logic [ENTRY_VALUE_W-1:0] entry_value;
        logic [ENTRY_INDEX_W-1:0] entry_index;
    } s_tdata_t;

    typedef struct packed {
        sel_t table_sel;
        op_t  op;
    } s_tuser_t;

    localparam int unsigned S_TDATA_W = $bits(s_tdata_t);
    localparam int unsigned S_TUSER_W = $bits(s_tuser_t);

endpackage

### rtl/vn3d_ram.sv
// Generic simple RAM: one write port, two read ports with registered read data.
// No dependencies; used for the permutation and value tables.
module vn3d_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data while the pipeline is stalled
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### rtl/vn3d_lerp.sv
// Registered fixed-point linear blend: q = (a*(1-t) + b*t) >> FRAC_BITS.
// No dependencies; one lane of the trilinear blend tree in the top level.
module vn3d_lerp #(
    parameter int unsigned VALUE_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [VALUE_BITS-1:0] a,
    input  logic [VALUE_BITS-1:0] b,
    input  logic [FRAC_BITS-1:0]  t,
    output logic [VALUE_BITS-1:0] q
);

    localparam int unsigned SUM_W = VALUE_BITS + FRAC_BITS + 1;

    logic [FRAC_BITS:0]    t_inv;
    logic [SUM_W-1:0]      prod_a;
    logic [SUM_W-2:0]      prod_b;
    logic [SUM_W-1:0]      sum;
    logic [VALUE_BITS-1:0] q_reg;

    assign t_inv  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, t};
    assign prod_a = SUM_W'(a) * SUM_W'(t_inv);
    assign prod_b = (SUM_W-1)'(b) * (SUM_W-1)'(t);
    assign sum    = prod_a + {1'b0, prod_b};

    // the blend never exceeds max(a, b), so the upper bits drop cleanly
    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= sum[FRAC_BITS +: VALUE_BITS];
        end
    end

    assign q = q_reg;

endmodule

### rtl/value_noise_3d_lattice_top.sv
// Throughput: one item per cycle while m_tready does not stall the pipeline; loads and
// queries may follow each other freely.
// Loads write the permutation tables in stage 1 and the value table in stage 2, the
// same slots where queries read them, so every access keeps stream order.
// A stall on m_tready freezes the whole six-register pipeline.
// Reset clears the valid bits only; tables stay undefined until loaded.
module value_noise_3d_lattice_top
    import vn3d_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = 256,
    parameter int unsigned FRAC_BITS  = 16,
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index[7:0], entry_value[23:8], coord_x[55:24], coord_y[87:56], coord_z[119:88]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0], table_sel[2:1]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // noise_value[15:0]
    output logic [NOISE_W-1:0]   m_tdata
);

    localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
    localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3) << FRAC_BITS;

    s_tdata_t in_data;
    s_tuser_t in_user;
    logic     adv;
    logic     s_accept;

    // stage 1: captured item
    logic                     s1_valid_reg;
    op_t                      s1_op_reg;
    sel_t                     s1_sel_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [ENTRY_VALUE_W-1:0] s1_val_reg;
    logic [COORD_W-1:0]       s1_coord_reg [AXES];

    // stage 2: perm data, f*f and 3-2f
    logic                     s2_valid_reg;
    op_t                      s2_op_reg;
    sel_t                     s2_sel_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic [ENTRY_VALUE_W-1:0] s2_val_reg;
    logic [FRAC_BITS-1:0]     s2_f2_reg   [AXES];
    logic [FRAC_BITS+1:0]     s2_k_reg    [AXES];
    logic [FRAC_BITS-1:0]     s2_f2_next  [AXES];
    logic [FRAC_BITS+1:0]     s2_k_next   [AXES];

    // stage 3: corner values and smoothed weights
    logic                     s3_qv_reg;
    logic [FRAC_BITS-1:0]     s3_wt_reg   [AXES];
    logic [FRAC_BITS-1:0]     s3_wt_next  [AXES];

    // stage 4 and 5: weights still to be used
    logic                     s4_qv_reg;
    logic [FRAC_BITS-1:0]     s4_wt_reg   [2];
    logic                     s5_qv_reg;
    logic [FRAC_BITS-1:0]     s5_wx_reg;
    logic                     m_valid_reg;

    logic [COORD_W*2-1:0]     coord_ext   [AXES];
    logic [IDX_W-1:0]         base_idx    [AXES];
    logic [IDX_W-1:0]         next_idx    [AXES];
    logic [FRAC_BITS-1:0]     frac        [AXES];
    logic [FRAC_BITS*2-1:0]   frac_sq     [AXES];
    logic [FRAC_BITS*2+1:0]   smooth_prod [AXES];
    logic [IDX_W-1:0]         perm_lo     [AXES];
    logic [IDX_W-1:0]         perm_hi     [AXES];
    logic                     perm_we     [AXES];
    logic [IDX_W-1:0]         hash        [CORNERS];
    logic [VALUE_BITS-1:0]    corner      [CORNERS];
    logic [VALUE_BITS-1:0]    blend_z     [4];
    logic [VALUE_BITS-1:0]    blend_y     [2];
    logic [VALUE_BITS-1:0]    blend_x;

    logic [IDX_W+ENTRY_INDEX_W-1:0]      idx_wide;
    logic [IDX_W+ENTRY_VALUE_W-1:0]      perm_val_wide;
    logic [VALUE_BITS+ENTRY_VALUE_W-1:0] tab_val_wide;
    logic [NOISE_W+VALUE_BITS-1:0]       noise_wide;
    logic                                value_we;

    assign in_data  = s_tdata_t'(s_tdata);
    assign in_user  = s_tuser_t'(s_tuser);
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;
    assign idx_wide = {{IDX_W{1'b0}}, in_data.entry_index};

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_qv_reg    <= 1'b0;
            s4_qv_reg    <= 1'b0;
            s5_qv_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_qv_reg    <= s2_valid_reg && (s2_op_reg == OP_QUERY);
            s4_qv_reg    <= s3_qv_reg;
            s5_qv_reg    <= s4_qv_reg;
            m_valid_reg  <= s5_qv_reg;
        end
    end

    // ---------------- stage 1 -> 2: addresses and fraction square ----------------
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            coord_ext[a]   = {{COORD_W{s1_coord_reg[a][COORD_W-1]}}, s1_coord_reg[a]};
            base_idx[a]    = coord_ext[a][FRAC_BITS +: IDX_W];
            next_idx[a]    = base_idx[a] + IDX_W'(1);
            frac[a]        = coord_ext[a][FRAC_BITS-1:0];
            frac_sq[a]     = (FRAC_BITS*2)'(frac[a]) * (FRAC_BITS*2)'(frac[a]);
            s2_f2_next[a]  = frac_sq[a][FRAC_BITS +: FRAC_BITS];
            s2_k_next[a]   = THREE_ONE - {1'b0, frac[a], 1'b0};
            perm_we[a]     = adv && s1_valid_reg && (s1_op_reg == OP_LOAD)
                             && (s1_sel_reg == PERM_SEL[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg       <= in_user.op;
            s1_sel_reg      <= in_user.table_sel;
            s1_idx_reg      <= idx_wide[IDX_W-1:0];
            s1_val_reg      <= in_data.entry_value;
            s1_coord_reg[0] <= in_data.coord_x;
            s1_coord_reg[1] <= in_data.coord_y;
            s1_coord_reg[2] <= in_data.coord_z;

            s2_op_reg  <= s1_op_reg;
            s2_sel_reg <= s1_sel_reg;
            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
            for (int a = 0; a < AXES; a++) begin
                s2_f2_reg[a] <= s2_f2_next[a];
                s2_k_reg[a]  <= s2_k_next[a];
            end

            for (int a = 0; a < AXES; a++) begin
                s3_wt_reg[a] <= s3_wt_next[a];
            end
            s4_wt_reg[0] <= s3_wt_reg[0];
            s4_wt_reg[1] <= s3_wt_reg[1];
            s5_wx_reg    <= s4_wt_reg[0];
        end
    end

    assign perm_val_wide = {{IDX_W{1'b0}}, s1_val_reg};

    for (genvar a = 0; a < AXES; a++) begin : g_perm
        vn3d_ram #(
            .WIDTH (IDX_W),
            .DEPTH (TABLE_SIZE)
        ) u_perm (
            .aclk    (aclk),
            .we      (perm_we[a]),
            .waddr   (s1_idx_reg),
            .wdata   (perm_val_wide[IDX_W-1:0]),
            .re      (adv),
            .raddr_a (base_idx[a]),
            .raddr_b (next_idx[a]),
            .rdata_a (perm_lo[a]),
            .rdata_b (perm_hi[a])
        );
    end

    // ---------------- stage 2 -> 3: corner hashes and Hermite weight ----------------
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            smooth_prod[a] = (FRAC_BITS*2+2)'(s2_f2_reg[a]) * (FRAC_BITS*2+2)'(s2_k_reg[a]);
            s3_wt_next[a]  = smooth_prod[a][FRAC_BITS +: FRAC_BITS];
        end
        // corner n: x offset is bit 2, y offset bit 1, z offset bit 0
        for (int n = 0; n < CORNERS; n++) begin
            hash[n] = (n[2] ? perm_hi[0] : perm_lo[0])
                    ^ (n[1] ? perm_hi[1] : perm_lo[1])
                    ^ (n[0] ? perm_hi[2] : perm_lo[2]);
        end
    end

    assign tab_val_wide = {{VALUE_BITS{1'b0}}, s2_val_reg};
    assign value_we     = adv && s2_valid_reg && (s2_op_reg == OP_LOAD)
                          && (s2_sel_reg == SEL_VALUE);

    // four copies of the value table give eight reads per cycle while the pipeline advances
    for (genvar k = 0; k < 4; k++) begin : g_value
        vn3d_ram #(
            .WIDTH (VALUE_BITS),
            .DEPTH (TABLE_SIZE)
        ) u_value (
            .aclk    (aclk),
            .we      (value_we),
            .waddr   (s2_idx_reg),
            .wdata   (tab_val_wide[VALUE_BITS-1:0]),
            .re      (adv),
            .raddr_a (hash[2*k]),
            .raddr_b (hash[2*k+1]),
            .rdata_a (corner[2*k]),
            .rdata_b (corner[2*k+1])
        );
    end

    // ---------------- stages 3 to 5: blend along z, then y, then x ----------------
    for (genvar k = 0; k < 4; k++) begin : g_blend_z
        vn3d_lerp #(
            .VALUE_BITS (VALUE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lerp (
            .aclk (aclk),
            .en   (adv),
            .a    (corner[2*k]),
            .b    (corner[2*k+1]),
            .t    (s3_wt_reg[2]),
            .q    (blend_z[k])
        );
    end

    for (genvar k = 0; k < 2; k++) begin : g_blend_y
        vn3d_lerp #(
            .VALUE_BITS (VALUE_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lerp (
            .aclk (aclk),
            .en   (adv),
            .a    (blend_z[2*k]),
            .b    (blend_z[2*k+1]),
            .t    (s4_wt_reg[1]),
            .q    (blend_y[k])
        );
    end

    vn3d_lerp #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_blend_x (
        .aclk (aclk),
        .en   (adv),
        .a    (blend_y[0]),
        .b    (blend_y[1]),
        .t    (s5_wx_reg),
        .q    (blend_x)
    );

    assign noise_wide = {{NOISE_W{1'b0}}, blend_x};
    assign m_tdata    = noise_wide[NOISE_W-1:0];
    assign m_tvalid   = m_valid_reg;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while the result register is stalled");

    a_result_from_query: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s5_qv_reg))
        else $error("result appeared without a query in the last stage");

    a_perm_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({perm_we[0], perm_we[1], perm_we[2]}))
        else $error("more than one permutation table written at once");

    a_no_write_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> (!value_we && !perm_we[0] && !perm_we[1] && !perm_we[2]))
        else $error("table written while the pipeline is frozen");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s1_valid_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule
